@@ hdl/peak_envelope_bound_search_defines.svh @@
// assertion macros shared by the checker of peak_envelope_bound_search
// no dependencies; included by bare file name
`ifndef PEAK_ENVELOPE_BOUND_SEARCH_DEFINES_SVH
`define PEAK_ENVELOPE_BOUND_SEARCH_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PEB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define PEB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/peb_pkg.sv @@
// shared types and constants for peak_envelope_bound_search
// no dependencies
package peb_pkg;

  localparam int MAX_PEAKS = 64;
  localparam int AW        = $clog2(MAX_PEAKS);      // peak memory address
  localparam int CW        = AW + 1;                 // peak count, holds MAX_PEAKS
  localparam int PEAK_W    = 32;
  localparam int REF_W     = 6;
  localparam int CNT_W     = 6;                      // result counts and clamps
  localparam int CF_W      = 17;
  localparam int FRAC_W    = 16;
  localparam int TW        = PEAK_W + AW;            // total intensity
  localparam int GOAL_W    = CF_W + TW;
  localparam int LO_W      = TW / 2;                 // multiplier split
  localparam int HI_W      = TW - LO_W;
  localparam int PROD_W    = CF_W + HI_W;
  localparam int CMP_W     = (REF_W > CW) ? REF_W : CW;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  localparam logic [CF_W-1:0]  COVERAGE_RST = CF_W'(55706);
  localparam logic [CNT_W-1:0] MAX_CNT_RST  = CNT_W'(63);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COVERAGE   = 2'd0,
    REG_MIN_INTENS = 2'd1,
    REG_MAX_BACK   = 2'd2,
    REG_MAX_FWD    = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_LO,
    S_MUL_HI,
    S_READ,
    S_EVAL,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [CF_W-1:0]   coverage;
    logic [PEAK_W-1:0] min_intens;
    logic [CNT_W-1:0]  max_back;
    logic [CNT_W-1:0]  max_fwd;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [REF_W-1:0] ref_idx;
  } walk_req_t;

  typedef struct packed {
    logic idle;
    logic clear;
  } walk_stat_t;

endpackage

@@ hdl/peb_mem.sv @@
// peak intensity memory: one write port, two registered read ports
// depends on peb_pkg
module peb_mem (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [peb_pkg::AW-1:0]     wr_addr,
  input  logic [peb_pkg::PEAK_W-1:0] wr_data,
  input  logic [peb_pkg::AW-1:0]     rd_addr_a,
  input  logic [peb_pkg::AW-1:0]     rd_addr_b,
  output logic [peb_pkg::PEAK_W-1:0] rd_data_a,
  output logic [peb_pkg::PEAK_W-1:0] rd_data_b
);

  logic [peb_pkg::PEAK_W-1:0] mem_r [peb_pkg::MAX_PEAKS];
  logic [peb_pkg::PEAK_W-1:0] rd_a_r;
  logic [peb_pkg::PEAK_W-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_a_r <= mem_r[rd_addr_a];
    rd_b_r <= mem_r[rd_addr_b];
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

@@ hdl/peb_seq.sv @@
// window growth sequencer: shared multiplier for the coverage goal, then one
// add and compare unit reused for every greedy step; holds the result register
// depends on peb_pkg
module peb_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  peb_pkg::cfg_t              cfg,
  input  peb_pkg::walk_req_t         req,
  input  logic [peb_pkg::CW-1:0]     peak_count,
  input  logic [peb_pkg::TW-1:0]     total,
  output logic [peb_pkg::AW-1:0]     rd_addr_a,
  output logic [peb_pkg::AW-1:0]     rd_addr_b,
  input  logic [peb_pkg::PEAK_W-1:0] rd_data_a,
  input  logic [peb_pkg::PEAK_W-1:0] rd_data_b,
  output peb_pkg::walk_stat_t        stat,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [peb_pkg::CNT_W-1:0]  out_back_count,
  output logic [peb_pkg::CNT_W-1:0]  out_forward_count,
  output logic                       out_bad_reference
);

  peb_pkg::state_t state_r, state_nxt;

  logic [peb_pkg::REF_W-1:0]  ref_r, ref_nxt;
  logic [peb_pkg::AW-1:0]     back_r, back_nxt;
  logic [peb_pkg::CW-1:0]     fwd_r, fwd_nxt;
  logic [peb_pkg::TW-1:0]     sum_r, sum_nxt;
  logic [peb_pkg::GOAL_W-1:0] goal_r, goal_nxt;
  logic                       bad_r, bad_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [peb_pkg::CNT_W-1:0]  obk_r, obk_nxt;
  logic [peb_pkg::CNT_W-1:0]  ofw_r, ofw_nxt;
  logic                       obad_r, obad_nxt;

  logic [peb_pkg::HI_W-1:0]   mul_op;
  logic [peb_pkg::PROD_W-1:0] prod;
  logic                       covered;
  logic                       has_back;
  logic                       has_fwd;
  logic [peb_pkg::PEAK_W-1:0] bi;
  logic [peb_pkg::PEAK_W-1:0] fi;
  logic [peb_pkg::CW-1:0]     bcnt;
  logic [peb_pkg::CW-1:0]     fcnt;
  logic                       clear;

  // one multiplier, used on the low then the high half of the total
  assign mul_op = (state_r == peb_pkg::S_MUL_HI) ? total[peb_pkg::TW-1:peb_pkg::LO_W]
                                                 : peb_pkg::HI_W'(total[peb_pkg::LO_W-1:0]);
  assign prod   = peb_pkg::PROD_W'(cfg.coverage) * peb_pkg::PROD_W'(mul_op);

  assign covered  = !(peb_pkg::GOAL_W'({sum_r, {peb_pkg::FRAC_W{1'b0}}}) < goal_r);
  assign has_back = (back_r != '0);
  assign has_fwd  = (fwd_r < peak_count);
  assign bi       = has_back ? rd_data_a : '0;
  assign fi       = has_fwd  ? rd_data_b : '0;
  assign bcnt     = peb_pkg::CW'(ref_r) - peb_pkg::CW'(back_r);
  assign fcnt     = fwd_r - peb_pkg::CW'(ref_r) - peb_pkg::CW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= peb_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ref_r  <= ref_nxt;
    back_r <= back_nxt;
    fwd_r  <= fwd_nxt;
    sum_r  <= sum_nxt;
    goal_r <= goal_nxt;
    bad_r  <= bad_nxt;
    obk_r  <= obk_nxt;
    ofw_r  <= ofw_nxt;
    obad_r <= obad_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    ref_nxt       = ref_r;
    back_nxt      = back_r;
    fwd_nxt       = fwd_r;
    sum_nxt       = sum_r;
    goal_nxt      = goal_r;
    bad_nxt       = bad_r;
    out_valid_nxt = out_valid_r && !out_ready;
    obk_nxt       = obk_r;
    ofw_nxt       = ofw_r;
    obad_nxt      = obad_r;
    clear         = 1'b0;
    rd_addr_a     = back_r - peb_pkg::AW'(1);
    rd_addr_b     = fwd_r[peb_pkg::AW-1:0];

    case (state_r)
      peb_pkg::S_IDLE: begin
        if (req.start) begin
          ref_nxt   = req.ref_idx;
          state_nxt = peb_pkg::S_MUL_LO;
        end
      end
      peb_pkg::S_MUL_LO: begin
        rd_addr_a = peb_pkg::AW'(ref_r);
        goal_nxt  = peb_pkg::GOAL_W'(prod);
        back_nxt  = peb_pkg::AW'(ref_r);
        fwd_nxt   = peb_pkg::CW'(ref_r) + peb_pkg::CW'(1);
        bad_nxt   = (peb_pkg::CMP_W'(ref_r) >= peb_pkg::CMP_W'(peak_count));
        state_nxt = bad_nxt ? peb_pkg::S_FINISH : peb_pkg::S_MUL_HI;
      end
      peb_pkg::S_MUL_HI: begin
        // reference peak arrives from the read issued last cycle
        sum_nxt   = peb_pkg::TW'(rd_data_a);
        goal_nxt  = goal_r + (peb_pkg::GOAL_W'(prod) << peb_pkg::LO_W);
        state_nxt = peb_pkg::S_READ;
      end
      peb_pkg::S_READ: begin
        state_nxt = peb_pkg::S_EVAL;
      end
      peb_pkg::S_EVAL: begin
        if (covered || (!has_back && !has_fwd) ||
            ((bi < cfg.min_intens) && (fi < cfg.min_intens))) begin
          state_nxt = peb_pkg::S_FINISH;
        end else if (!has_fwd || (bi > fi)) begin
          sum_nxt   = sum_r + peb_pkg::TW'(bi);
          back_nxt  = back_r - peb_pkg::AW'(1);
          state_nxt = peb_pkg::S_READ;
        end else begin
          sum_nxt   = sum_r + peb_pkg::TW'(fi);
          fwd_nxt   = fwd_r + peb_pkg::CW'(1);
          state_nxt = peb_pkg::S_READ;
        end
      end
      peb_pkg::S_FINISH: begin
        // wait for the result register to drain
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          obad_nxt      = bad_r;
          clear         = 1'b1;
          state_nxt     = peb_pkg::S_IDLE;
          if (bad_r) begin
            obk_nxt = '0;
            ofw_nxt = '0;
          end else begin
            obk_nxt = (peb_pkg::CMP_W'(bcnt) > peb_pkg::CMP_W'(cfg.max_back)) ?
                      cfg.max_back : peb_pkg::CNT_W'(bcnt);
            ofw_nxt = (peb_pkg::CMP_W'(fcnt) > peb_pkg::CMP_W'(cfg.max_fwd)) ?
                      cfg.max_fwd : peb_pkg::CNT_W'(fcnt);
          end
        end
      end
      default: begin
        state_nxt = peb_pkg::S_IDLE;
      end
    endcase
  end

  assign stat.idle         = (state_r == peb_pkg::S_IDLE);
  assign stat.clear        = clear;
  assign out_valid         = out_valid_r;
  assign out_back_count    = obk_r;
  assign out_forward_count = ofw_r;
  assign out_bad_reference = obad_r;

endmodule

@@ hdl/peak_envelope_bound_search.sv @@
// peaks load one item per cycle while the sequencer is idle; the last item starts
// the walk: the multiplier states, then a read/evaluate loop around the shared add
// and compare unit and the peak memory for each peak added, then the finish state
// (a bad reference goes straight to finish); input stalls until the walk ends
// reset: synchronous active low; configuration registers to defaults, count and
// total cleared, peak memory contents are not cleared
module peak_envelope_bound_search (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [peb_pkg::PEAK_W-1:0]    in_peak_intensity,
  input  logic [peb_pkg::REF_W-1:0]     in_reference_index,
  input  logic                          in_last_peak,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [peb_pkg::CNT_W-1:0]     out_back_count,
  output logic [peb_pkg::CNT_W-1:0]     out_forward_count,
  output logic                          out_bad_reference,
  input  logic                          cfg_wr_en,
  input  logic [peb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [peb_pkg::CFG_DAT_W-1:0] cfg_wdata
);

  peb_pkg::cfg_t       cfg_r, cfg_nxt;
  logic [peb_pkg::CW-1:0] count_r, count_nxt;
  logic [peb_pkg::TW-1:0] total_r, total_nxt;
  peb_pkg::walk_req_t  req;
  peb_pkg::walk_stat_t stat;
  logic                accept;
  logic                store;
  logic [peb_pkg::AW-1:0]     rd_addr_a;
  logic [peb_pkg::AW-1:0]     rd_addr_b;
  logic [peb_pkg::PEAK_W-1:0] rd_data_a;
  logic [peb_pkg::PEAK_W-1:0] rd_data_b;

  assign in_ready = stat.idle;
  assign accept   = in_valid && in_ready;
  // items past the memory depth are dropped
  assign store    = accept && (count_r < peb_pkg::CW'(peb_pkg::MAX_PEAKS));

  assign req.start   = accept && in_last_peak;
  assign req.ref_idx = in_reference_index;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        peb_pkg::REG_COVERAGE:   cfg_nxt.coverage   = cfg_wdata[peb_pkg::CF_W-1:0];
        peb_pkg::REG_MIN_INTENS: cfg_nxt.min_intens = cfg_wdata[peb_pkg::PEAK_W-1:0];
        peb_pkg::REG_MAX_BACK:   cfg_nxt.max_back   = cfg_wdata[peb_pkg::CNT_W-1:0];
        peb_pkg::REG_MAX_FWD:    cfg_nxt.max_fwd    = cfg_wdata[peb_pkg::CNT_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    count_nxt = count_r;
    total_nxt = total_r;
    if (stat.clear) begin
      count_nxt = '0;
      total_nxt = '0;
    end else if (store) begin
      count_nxt = count_r + peb_pkg::CW'(1);
      total_nxt = total_r + peb_pkg::TW'(in_peak_intensity);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coverage   <= peb_pkg::COVERAGE_RST;
      cfg_r.min_intens <= '0;
      cfg_r.max_back   <= peb_pkg::MAX_CNT_RST;
      cfg_r.max_fwd    <= peb_pkg::MAX_CNT_RST;
      count_r          <= '0;
      total_r          <= '0;
    end else begin
      cfg_r   <= cfg_nxt;
      count_r <= count_nxt;
      total_r <= total_nxt;
    end
  end

  peb_mem u_mem (
    .clk       (clk),
    .wr_en     (store),
    .wr_addr   (count_r[peb_pkg::AW-1:0]),
    .wr_data   (in_peak_intensity),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  peb_seq u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .req               (req),
    .peak_count        (count_r),
    .total             (total_r),
    .rd_addr_a         (rd_addr_a),
    .rd_addr_b         (rd_addr_b),
    .rd_data_a         (rd_data_a),
    .rd_data_b         (rd_data_b),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_back_count    (out_back_count),
    .out_forward_count (out_forward_count),
    .out_bad_reference (out_bad_reference)
  );

endmodule

@@ hdl/peak_envelope_bound_search_chk.sv @@
// port-level checker for peak_envelope_bound_search, bound to the top level
// depends on peb_pkg and peak_envelope_bound_search_defines.svh
`include "peak_envelope_bound_search_defines.svh"

module peak_envelope_bound_search_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_last_peak,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [peb_pkg::CNT_W-1:0]     out_back_count,
  input logic [peb_pkg::CNT_W-1:0]     out_forward_count,
  input logic                          out_bad_reference
);

  // a stalled result item holds
  `PEB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_back_count) && $stable(out_forward_count) &&
    $stable(out_bad_reference), "result item changed while stalled")

  // bad reference carries empty window
  `PEB_ASSERT_NOW(a_bad_zero, out_valid && out_bad_reference,
    (out_back_count == '0) && (out_forward_count == '0),
    "bad reference with nonzero counts")

  // last item starts the walk, input stalls
  `PEB_ASSERT_NEXT(a_last_busy, in_valid && in_ready && in_last_peak, !in_ready,
    "input ready right after last item")

  // ordinary peaks stream without stalling
  `PEB_ASSERT_NEXT(a_load_stream, in_valid && in_ready && !in_last_peak, in_ready,
    "input stalled during peak loading")

endmodule

bind peak_envelope_bound_search peak_envelope_bound_search_chk u_chk (.*);
